// ----- sv/lmbs_pkg.sv -----
// Package for the LED matrix bitplane scanner.
// Shared types, codes and default constants; used by every module of the block.
// No dependencies.
package lmbs_pkg;

  localparam int PANEL_ROWS_DEF      = 64;
  localparam int PANEL_COLS_DEF      = 64;
  localparam int ROW_SELECT_BITS_DEF = 5;

  localparam int COLOR_W    = 24;
  localparam int BASE_W     = 10;
  localparam int ON_TIME_W  = 17;
  localparam int ROW_ADDR_W = 5;
  localparam int PLANE_W    = 3;
  localparam int POS_W      = 8;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;

  localparam logic [BASE_W-1:0]  BASE_RESET = 10'd100;
  localparam logic [PLANE_W-1:0] PLANE_LAST = 3'd7;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_FLIP  = 2'd2,
    MODE_SCAN  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_DUMMY = 2'd2,
    KIND_LATCH = 2'd3
  } kind_e;

  // Per-word side information carried from acceptance to the result stage.
  typedef struct packed {
    kind_e                 kind;
    logic [PLANE_W-1:0]    plane;
    logic [ROW_ADDR_W-1:0] row_addr;
    logic [ON_TIME_W-1:0]  on_time;
    logic                  swapped;
    logic                  frame_end;
    logic                  top_ok;
    logic                  bot_ok;
    logic                  rd_ok;
  } scan_info_t;

  typedef struct packed {
    logic front;
    logic pending;
    logic done;
  } flip_state_t;

endpackage

// ----- sv/lmbs_frame_buf.sv -----
// Double frame store: one write port, two registered read ports.
// Sweeps the whole store to zero after reset. Depends on lmbs_pkg.
module lmbs_frame_buf #(
  parameter int PANEL_ROWS = lmbs_pkg::PANEL_ROWS_DEF,
  parameter int PANEL_COLS = lmbs_pkg::PANEL_COLS_DEF,
  localparam int AW = 1 + $clog2(PANEL_ROWS) + $clog2(PANEL_COLS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [lmbs_pkg::COLOR_W-1:0] wr_data_i,
  input  logic                        rd_en_i,
  input  logic [AW-1:0]               rd_addr_a_i,
  input  logic [AW-1:0]               rd_addr_b_i,
  output logic [lmbs_pkg::COLOR_W-1:0] rd_data_a_o,
  output logic [lmbs_pkg::COLOR_W-1:0] rd_data_b_o,
  output logic                        clearing_o
);

  localparam int DEPTH = 2 ** AW;

  logic [lmbs_pkg::COLOR_W-1:0] mem [DEPTH];
  logic [lmbs_pkg::COLOR_W-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0]                clr_addr_q, clr_addr_d;
  logic                         clearing_q, clearing_d;
  logic                         we;
  logic [AW-1:0]                waddr;
  logic [lmbs_pkg::COLOR_W-1:0] wdata;

  always_comb begin
    clr_addr_d = clr_addr_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (&clr_addr_q) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clearing_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clearing_q <= clearing_d;
    end
  end

  // The sweep owns the write port until it ends.
  assign we    = clearing_q | wr_en_i;
  assign waddr = clearing_q ? clr_addr_q : wr_addr_i;
  assign wdata = clearing_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_a_q <= mem[rd_addr_a_i];
      rd_b_q <= mem[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;
  assign clearing_o  = clearing_q;

endmodule

// ----- sv/lmbs_scan_seq.sv -----
// Scan sequencer: slot, plane and row counters, flip handshake and on-time register.
// Produces the side information for each accepted word. Depends on lmbs_pkg.
module lmbs_scan_seq #(
  parameter int PANEL_ROWS      = lmbs_pkg::PANEL_ROWS_DEF,
  parameter int PANEL_COLS      = lmbs_pkg::PANEL_COLS_DEF,
  parameter int ROW_SELECT_BITS = lmbs_pkg::ROW_SELECT_BITS_DEF,
  localparam int CB = $clog2(PANEL_COLS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  lmbs_pkg::mode_e              mode_i,
  input  logic                         cfg_we_i,
  input  logic [lmbs_pkg::BASE_W-1:0]  cfg_wdata_i,
  output lmbs_pkg::scan_info_t         info_o,
  output lmbs_pkg::flip_state_t        flip_o,
  output logic [lmbs_pkg::POS_W-1:0]   top_row_o,
  output logic [lmbs_pkg::POS_W-1:0]   bot_row_o,
  output logic [CB-1:0]                col_o
);

  localparam int SLOT_W = $clog2(PANEL_COLS + 2);

  logic [SLOT_W-1:0]            slot_q, slot_d;
  logic [lmbs_pkg::PLANE_W-1:0] plane_q, plane_d;
  logic [ROW_SELECT_BITS-1:0]   row_q, row_d;
  logic                         front_q, front_d;
  logic                         pend_q, pend_d;
  logic                         done_q, done_d;
  logic [lmbs_pkg::BASE_W-1:0]  base_q;
  logic                         step, is_pixel, is_dummy, slot_last, frame_end;
  logic [lmbs_pkg::POS_W-1:0]   top_row, bot_row;

  assign step      = accept_i && (mode_i == lmbs_pkg::MODE_SCAN);
  assign is_pixel  = slot_q < SLOT_W'(PANEL_COLS);
  assign is_dummy  = slot_q == SLOT_W'(PANEL_COLS);
  assign slot_last = slot_q == SLOT_W'(PANEL_COLS + 1);
  assign frame_end = step && slot_last && (plane_q == lmbs_pkg::PLANE_LAST) && (&row_q);

  assign top_row = lmbs_pkg::POS_W'(row_q);
  assign bot_row = lmbs_pkg::POS_W'(PANEL_ROWS / 2) + lmbs_pkg::POS_W'(row_q);

  always_comb begin
    slot_d  = slot_q;
    plane_d = plane_q;
    row_d   = row_q;
    front_d = front_q;
    pend_d  = pend_q;
    done_d  = done_q;
    if (step) begin
      if (slot_last) begin
        slot_d = '0;
        if (plane_q == lmbs_pkg::PLANE_LAST) begin
          plane_d = '0;
          row_d   = row_q + ROW_SELECT_BITS'(1);
        end else begin
          plane_d = plane_q + lmbs_pkg::PLANE_W'(1);
        end
      end else begin
        slot_d = slot_q + SLOT_W'(1);
      end
    end
    if (frame_end && pend_q) begin
      front_d = ~front_q;
      pend_d  = 1'b0;
      done_d  = 1'b1;
    end
    if (accept_i && (mode_i == lmbs_pkg::MODE_FLIP)) begin
      pend_d = 1'b1;
      done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      plane_q <= '0;
      row_q   <= '0;
      front_q <= 1'b0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
      base_q  <= lmbs_pkg::BASE_RESET;
    end else begin
      slot_q  <= slot_d;
      plane_q <= plane_d;
      row_q   <= row_d;
      front_q <= front_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    info_o           = '0;
    info_o.kind      = lmbs_pkg::KIND_NONE;
    info_o.plane     = plane_q;
    info_o.swapped   = done_d;
    info_o.frame_end = frame_end;
    if (step) begin
      priority if (is_pixel) begin
        info_o.kind   = lmbs_pkg::KIND_PIXEL;
        info_o.top_ok = top_row < lmbs_pkg::POS_W'(PANEL_ROWS);
        info_o.bot_ok = bot_row < lmbs_pkg::POS_W'(PANEL_ROWS);
      end else if (is_dummy) begin
        info_o.kind = lmbs_pkg::KIND_DUMMY;
      end else begin
        info_o.kind     = lmbs_pkg::KIND_LATCH;
        info_o.row_addr = lmbs_pkg::ROW_ADDR_W'(row_q);
        info_o.on_time  = lmbs_pkg::ON_TIME_W'(base_q) << plane_q;
      end
    end
  end

  assign flip_o    = '{front: front_q, pending: pend_q, done: done_q};
  assign top_row_o = top_row;
  assign bot_row_o = bot_row;
  assign col_o     = slot_q[CB-1:0];

endmodule

// ----- sv/led_matrix_bitplane_scanner_core.sv -----
// Top level of the LED matrix bitplane scanner: stream ports, two-stage pipeline.
// Depends on lmbs_pkg, lmbs_frame_buf and lmbs_scan_seq.
//
//   channel   direction  payload                                   handshake
//   s_axis    in         tuser mode, tdata row/col/color            tvalid/tready
//   m_axis    out        tuser scan_kind, tlast frame_end, tdata    tvalid/tready
//   cfg       in         cfg_wdata_i base_on_time                   cfg_we_i
//
// One word per cycle sustained while m_axis_tready stays high; the path runs through
// the frame store read register, then the result register. Both lane pixels of a scan slot
// come from the two read ports of the frame store in the same cycle.
// After reset the store is swept to zero, one entry a cycle over all 2 * 2^(clog2(rows) +
// clog2(cols)) entries (8192 at 64 x 64), with s_axis_tready low.
// s_axis_tready drops only during the sweep, or while both stages hold words and m_axis_tready is low.
module led_matrix_bitplane_scanner_core #(
  parameter int PANEL_ROWS      = lmbs_pkg::PANEL_ROWS_DEF,
  parameter int PANEL_COLS      = lmbs_pkg::PANEL_COLS_DEF,
  parameter int ROW_SELECT_BITS = lmbs_pkg::ROW_SELECT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // row [7:0], col [15:8], color [39:16]
  input  logic [lmbs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // mode [1:0]
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // top_bits [2:0], bottom_bits [5:3], row_address [10:6], on_time [27:11],
  // read_data [51:28], swapped [52], zero [55:53]
  output logic [lmbs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // scan_kind [1:0]
  output logic [1:0]                      m_axis_tuser,
  // frame_end
  output logic                            m_axis_tlast,
  input  logic                            cfg_we_i,
  input  logic [lmbs_pkg::BASE_W-1:0]     cfg_wdata_i
);

  localparam int RB = $clog2(PANEL_ROWS);
  localparam int CB = $clog2(PANEL_COLS);
  localparam int AW = 1 + RB + CB;

  logic                            accept, adv, clearing, in_range, rd_en, wr_en;
  lmbs_pkg::mode_e                 mode;
  logic [lmbs_pkg::POS_W-1:0]      row_f, col_f;
  logic [lmbs_pkg::COLOR_W-1:0]    color_f;
  lmbs_pkg::scan_info_t            info, s1_info_q, s1_info_d;
  lmbs_pkg::flip_state_t           flip;
  logic [lmbs_pkg::POS_W-1:0]      top_row, bot_row;
  logic [CB-1:0]                   scan_col;
  logic [AW-1:0]                   wr_addr, rd_addr_a, rd_addr_b;
  logic [lmbs_pkg::COLOR_W-1:0]    rd_a, rd_b;
  logic                            s1_valid_q, out_valid_q;
  logic [lmbs_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic [1:0]                      out_user_q;
  logic                            out_last_q;
  logic [2:0]                      top_bits, bot_bits;
  logic [lmbs_pkg::COLOR_W-1:0]    read_data;
  logic [7:0]                      a_r, a_g, a_b, b_r, b_g, b_b;

  assign mode    = lmbs_pkg::mode_e'(s_axis_tuser);
  assign row_f   = s_axis_tdata[7:0];
  assign col_f   = s_axis_tdata[15:8];
  assign color_f = s_axis_tdata[39:16];

  // Result stage frees up when empty or when its word leaves this cycle.
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !clearing && (!s1_valid_q || adv);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_range = !row_f[7] && !col_f[7] &&
                    (row_f < lmbs_pkg::POS_W'(PANEL_ROWS)) &&
                    (col_f < lmbs_pkg::POS_W'(PANEL_COLS));

  assign wr_en     = accept && (mode == lmbs_pkg::MODE_WRITE) && in_range;
  assign rd_en     = accept && ((mode == lmbs_pkg::MODE_READ) || (mode == lmbs_pkg::MODE_SCAN));
  assign wr_addr   = {~flip.front, row_f[RB-1:0], col_f[CB-1:0]};
  assign rd_addr_a = (mode == lmbs_pkg::MODE_READ) ?
                     {flip.front, row_f[RB-1:0], col_f[CB-1:0]} :
                     {flip.front, top_row[RB-1:0], scan_col};
  assign rd_addr_b = {flip.front, bot_row[RB-1:0], scan_col};

  lmbs_frame_buf #(
    .PANEL_ROWS (PANEL_ROWS),
    .PANEL_COLS (PANEL_COLS)
  ) u_frame_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (color_f),
    .rd_en_i     (rd_en),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (rd_a),
    .rd_data_b_o (rd_b),
    .clearing_o  (clearing)
  );

  lmbs_scan_seq #(
    .PANEL_ROWS      (PANEL_ROWS),
    .PANEL_COLS      (PANEL_COLS),
    .ROW_SELECT_BITS (ROW_SELECT_BITS)
  ) u_scan_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .mode_i      (mode),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .info_o      (info),
    .flip_o      (flip),
    .top_row_o   (top_row),
    .bot_row_o   (bot_row),
    .col_o       (scan_col)
  );

  // Stage one: side information beside the frame store read register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_comb begin
    s1_info_d       = info;
    s1_info_d.rd_ok = (mode == lmbs_pkg::MODE_READ) && in_range;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_info_q <= s1_info_d;
    end
  end

  // Pick the current plane out of each color byte.
  assign a_r = rd_a[7:0];
  assign a_g = rd_a[15:8];
  assign a_b = rd_a[23:16];
  assign b_r = rd_b[7:0];
  assign b_g = rd_b[15:8];
  assign b_b = rd_b[23:16];

  assign top_bits  = s1_info_q.top_ok ?
                     {a_b[s1_info_q.plane], a_g[s1_info_q.plane], a_r[s1_info_q.plane]} : '0;
  assign bot_bits  = s1_info_q.bot_ok ?
                     {b_b[s1_info_q.plane], b_g[s1_info_q.plane], b_r[s1_info_q.plane]} : '0;
  assign read_data = s1_info_q.rd_ok ? rd_a : '0;

  assign out_data_d = {3'b000, s1_info_q.swapped, read_data, s1_info_q.on_time,
                       s1_info_q.row_addr, bot_bits, top_bits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      out_data_q <= out_data_d;
      out_user_q <= 2'(s1_info_q.kind);
      out_last_q <= s1_info_q.frame_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  a_no_accept_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) clearing |-> !s_axis_tready
  ) else $error("input accepted during frame store sweep");

  a_last_is_latch : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == 2'(lmbs_pkg::KIND_LATCH))
  ) else $error("frame end on a word that is not a latch");

  a_flip_exclusive : assert property (
    @(posedge clk_i) disable iff (!rst_ni) !(flip.pending && flip.done)
  ) else $error("flip pending and done at once");

  a_stage_holds : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && m_axis_tvalid && !m_axis_tready) |=> s1_valid_q
  ) else $error("stalled word dropped from the read stage");

endmodule

// ----- bench/led_matrix_bitplane_scanner_core_test.sv -----
// Self-checking bench for led_matrix_bitplane_scanner_core: pixel writes, reads,
// flips and scan ticks go in, and every result word is checked against a local model.
// Depends on lmbs_pkg and the core RTL.
module led_matrix_bitplane_scanner_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS        = lmbs_pkg::PANEL_ROWS_DEF;
  localparam int COLS        = lmbs_pkg::PANEL_COLS_DEF;
  localparam int ROW_ADDRS   = 1 << lmbs_pkg::ROW_SELECT_BITS_DEF;
  localparam int PIX         = ROWS * COLS;
  localparam int PLANES      = 8;
  localparam int SLOTS       = COLS + 2;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_LEN    = 600;

  typedef struct packed {
    lmbs_pkg::mode_e mode;
    logic [7:0]      row;
    logic [7:0]      col;
    logic [23:0]     color;
  } pixel_cmd_t;

  typedef struct packed {
    lmbs_pkg::kind_e kind;
    logic [2:0]      top;
    logic [2:0]      bot;
    logic [4:0]      row_addr;
    logic [16:0]     on_time;
    logic [23:0]     rdata;
    logic            swapped;
    logic            frame_end;
  } scan_result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [lmbs_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]                      s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [lmbs_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]                      m_axis_tuser;
  logic                            m_axis_tlast;
  logic                            cfg_we_i = 1'b0;
  logic [lmbs_pkg::BASE_W-1:0]     cfg_wdata_i = '0;

  led_matrix_bitplane_scanner_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Local copy of the framebuffer and scan state
  logic [23:0]  pix_store [0:2*PIX-1];
  bit           front_buf;
  bit           flip_wait;
  bit           flip_seen;
  int           scan_row;
  int           scan_plane;
  int           scan_slot;
  logic [9:0]   on_base = lmbs_pkg::BASE_RESET;

  pixel_cmd_t   cmd_q[$];
  scan_result_t result_q[$];
  int           errors;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [2:0] lane_bits(int buffer, int r, int c, int plane);
    logic [23:0] px;
    if (r >= ROWS || c >= COLS) return 3'b000;
    px = pix_store[buffer * PIX + r * COLS + c];
    return {px[plane + 16], px[plane + 8], px[plane]};
  endfunction

  task automatic predict_word(input pixel_cmd_t cmd);
    scan_result_t res;
    int r;
    int c;
    int addr;
    int fb;
    bit hit;
    res = '0;
    res.kind = lmbs_pkg::KIND_NONE;
    r = int'($signed(cmd.row));
    c = int'($signed(cmd.col));
    hit = (r >= 0 && c >= 0 && r < ROWS && c < COLS);
    addr = r * COLS + c;
    fb = int'(front_buf);
    unique case (cmd.mode)
      lmbs_pkg::MODE_WRITE: begin
        if (hit) pix_store[(fb ^ 1) * PIX + addr] = cmd.color;
      end
      lmbs_pkg::MODE_READ: begin
        if (hit) res.rdata = pix_store[fb * PIX + addr];
      end
      lmbs_pkg::MODE_FLIP: begin
        flip_wait = 1'b1;
        flip_seen = 1'b0;
      end
      default: begin
        if (scan_slot < COLS) begin
          res.kind = lmbs_pkg::KIND_PIXEL;
          res.top = lane_bits(fb, scan_row, scan_slot, scan_plane);
          res.bot = lane_bits(fb, ROWS / 2 + scan_row, scan_slot, scan_plane);
        end else if (scan_slot == COLS) begin
          res.kind = lmbs_pkg::KIND_DUMMY;
        end else begin
          res.kind = lmbs_pkg::KIND_LATCH;
          res.row_addr = 5'(scan_row & 31);
          res.on_time = 17'(17'(on_base) << scan_plane);
        end
        scan_slot++;
        if (scan_slot >= SLOTS) begin
          scan_slot = 0;
          scan_plane++;
          if (scan_plane >= PLANES) begin
            scan_plane = 0;
            scan_row++;
            if (scan_row >= ROW_ADDRS) begin
              scan_row = 0;
              res.frame_end = 1'b1;
              // swap roles only when a flip is waiting
              if (flip_wait) begin
                front_buf = ~front_buf;
                flip_wait = 1'b0;
                flip_seen = 1'b1;
              end
            end
          end
        end
      end
    endcase
    res.swapped = flip_seen;
    result_q.push_back(res);
  endtask

  // Driver: bursts of words with random gaps, fed from cmd_q
  int         burst_left;
  int         gap_left;
  pixel_cmd_t cur_cmd;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_word(cur_cmd);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          cur_cmd = cmd_q.pop_front();
          s_axis_tdata <= {cur_cmd.color, cur_cmd.col, cur_cmd.row};
          s_axis_tuser <= cur_cmd.mode;
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(100, 400)
                                                   : $urandom_range(1, 40);
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Monitor and receiver: random stall styles picked by style_cnt, one long hold
  int           words_seen;
  int           hold_left;
  int           style_cnt;
  int           stall_style;
  scan_result_t want;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      words_seen = 0;
      hold_left = 0;
      style_cnt = 0;
      stall_style = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected word, expected none actual tdata %0h", $time,
                   m_axis_tdata);
          errors++;
        end else begin
          want = result_q.pop_front();
          check_field("scan_kind", want.kind, m_axis_tuser);
          check_field("top_bits", want.top, m_axis_tdata[2:0]);
          check_field("bottom_bits", want.bot, m_axis_tdata[5:3]);
          check_field("row_address", want.row_addr, m_axis_tdata[10:6]);
          check_field("on_time", want.on_time, m_axis_tdata[27:11]);
          check_field("read_data", want.rdata, m_axis_tdata[51:28]);
          check_field("swapped", want.swapped, m_axis_tdata[52]);
          check_field("pad", 0, m_axis_tdata[55:53]);
          check_field("frame_end", want.frame_end, m_axis_tlast);
        end
        words_seen++;
        if (words_seen == HOLD_AT) hold_left = HOLD_LEN;
      end
      style_cnt++;
      if (style_cnt % 512 == 0) stall_style = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        unique case (stall_style)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 7) != 0);
          default: m_axis_tready <= (style_cnt % 5 != 0);
        endcase
      end
    end
  end

  int cycles;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_cmd(input pixel_cmd_t cmd);
    cmd_q.push_back(cmd);
  endtask

  task automatic push_fields(input lmbs_pkg::mode_e mode, input int r, input int c,
                             input logic [23:0] color);
    pixel_cmd_t cmd;
    cmd.mode = mode;
    cmd.row = 8'(r);
    cmd.col = 8'(c);
    cmd.color = color;
    push_cmd(cmd);
  endtask

  // Mostly on-panel, often near the corners so reads find written pixels
  function automatic logic [7:0] rand_pos();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 8'($urandom);
    if (pick <= 3) return 8'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                   : $urandom_range(60, 63));
    return 8'($urandom_range(0, 63));
  endfunction

  function automatic pixel_cmd_t rand_cmd();
    pixel_cmd_t cmd;
    int pick;
    pick = $urandom_range(0, 99);
    cmd.color = 24'($urandom);
    cmd.row = rand_pos();
    cmd.col = rand_pos();
    if (pick < 40) cmd.mode = lmbs_pkg::MODE_WRITE;
    else if (pick < 70) cmd.mode = lmbs_pkg::MODE_READ;
    else if (pick < 75) cmd.mode = lmbs_pkg::MODE_FLIP;
    else cmd.mode = lmbs_pkg::MODE_SCAN;
    if (cmd.mode != lmbs_pkg::MODE_WRITE && cmd.mode != lmbs_pkg::MODE_READ) begin
      cmd.row = 8'($urandom);
      cmd.col = 8'($urandom);
    end
    return cmd;
  endfunction

  task automatic queue_episode(input int n_misc);
    repeat (n_misc) push_cmd(rand_cmd());
  endtask

  task automatic wait_idle();
    while (!(cmd_q.size() == 0 && !s_axis_tvalid && result_q.size() == 0))
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [9:0] value);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    on_base = value;
  endtask

  initial begin
    for (int i = 0; i < 2 * PIX; i++) pix_store[i] = '0;
    front_buf = 1'b0;
    flip_wait = 1'b0;
    flip_seen = 1'b0;
    scan_row = 0;
    scan_plane = 0;
    scan_slot = 0;
    errors = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: corners, off-panel writes and reads, double flip, first ticks
    push_fields(lmbs_pkg::MODE_WRITE, 0, 0, 24'hFFFFFF);
    push_fields(lmbs_pkg::MODE_WRITE, 63, 63, 24'hA5C3F0);
    push_fields(lmbs_pkg::MODE_WRITE, 0, 63, 24'h000001);
    push_fields(lmbs_pkg::MODE_WRITE, 63, 0, 24'h800000);
    push_fields(lmbs_pkg::MODE_WRITE, 32, 0, 24'h123456);
    push_fields(lmbs_pkg::MODE_WRITE, -1, 0, 24'hFFFFFF);
    push_fields(lmbs_pkg::MODE_WRITE, 64, 0, 24'hFFFFFF);
    push_fields(lmbs_pkg::MODE_WRITE, 0, 64, 24'hFFFFFF);
    push_fields(lmbs_pkg::MODE_WRITE, -128, -128, 24'hFFFFFF);
    push_fields(lmbs_pkg::MODE_WRITE, 127, 127, 24'hFFFFFF);
    push_fields(lmbs_pkg::MODE_READ, 0, 0, 24'hFFFFFF);
    push_fields(lmbs_pkg::MODE_READ, -128, 127, 24'h000000);
    push_fields(lmbs_pkg::MODE_READ, 127, -1, 24'h5A5A5A);
    push_fields(lmbs_pkg::MODE_FLIP, 0, 0, 24'h000000);
    push_fields(lmbs_pkg::MODE_FLIP, -1, -1, 24'hFFFFFF);
    push_fields(lmbs_pkg::MODE_SCAN, 0, 0, 24'h000000);
    push_fields(lmbs_pkg::MODE_SCAN, -1, -1, 24'hFFFFFF);
    push_fields(lmbs_pkg::MODE_SCAN, 5, 5, 24'h0F0F0F);
    queue_episode(300);
    // the front buffer keeps its cleared image while the flip waits
    push_fields(lmbs_pkg::MODE_READ, 0, 0, 24'h000000);
    push_fields(lmbs_pkg::MODE_READ, 63, 63, 24'h000000);
    push_fields(lmbs_pkg::MODE_READ, 32, 0, 24'h000000);

    write_base(10'd1023);
    queue_episode(300);

    write_base(10'd1);
    queue_episode(300);

    write_base(10'($urandom_range(1, 1023)));
    queue_episode(275);

    write_base(10'($urandom_range(1, 1023)));
    queue_episode(275);

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
